@@ rtl/stream_suffix_dictionary_matcher_macros.svh @@
// Assertion macros for the checker file.
`ifndef STREAM_SUFFIX_DICTIONARY_MATCHER_MACROS_SVH
`define STREAM_SUFFIX_DICTIONARY_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SSDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define SSDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ssdm_pkg.sv @@
`default_nettype none
package ssdm_pkg;
	localparam int LETTER_W = 5;

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic [LETTER_W-1:0] letter;
		logic                word_done;
	} item_t;

	typedef struct packed {
		logic matched;
		logic status;
	} result_t;

	typedef struct packed {
		logic ld;
		logic clr;
		logic sweep;
		logic ring_wr;
		logic child_q;
		logic term_q;
		logic step;
		logic alloc;
		logic adv;
		logic set_skip;
		logic set_full;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       letter_bad;
		logic       skip;
		logic       ring_bad;
		logic       child_bad;
		logic       child_zero;
		logic       full;
		logic       term_hit;
		logic       last_step;
		logic       sweep_last;
		logic       status;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/ssdm_ram.sv @@
`default_nettype none
module ssdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic [AW-1:0]    addr,
	input  wire logic             we,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ rtl/ssdm_datapath.sv @@
`default_nettype none
module ssdm_datapath #(
	parameter int NODE_COUNT = 4096,
	parameter int MAX_WORD_LEN = 256,
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ssdm_pkg::item_t item,
	input  wire ssdm_pkg::cmd_t  cmd,
	output ssdm_pkg::sts_t       sts
);
	import ssdm_pkg::*;

	localparam int NW  = $clog2(NODE_COUNT);
	localparam int NUW = NW + 1;
	localparam int CD  = NODE_COUNT * ALPHABET_SIZE;
	localparam int CW  = $clog2(CD);
	localparam int HW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int FW  = $clog2(MAX_WORD_LEN + 1);

	logic [1:0]          op_q;
	logic [LETTER_W-1:0] letter_q;
	logic                word_done_q;
	logic [NW-1:0]       node_q;
	logic [NW-1:0]       cursor_q;
	logic [NUW-1:0]      nodes_used_q;
	logic                skip_q;
	logic                status_q;
	logic [HW-1:0]       head_q;
	logic [HW-1:0]       pos_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       step_q;
	logic [CW-1:0]       sweep_q;

	logic [CW-1:0]       child_addr;
	logic                child_we;
	logic [NW-1:0]       child_wdata;
	logic [NW-1:0]       child_rdata;
	logic [NW-1:0]       term_addr;
	logic                term_we;
	logic                term_rdata;
	logic [HW-1:0]       ring_addr;
	logic [LETTER_W-1:0] ring_rdata;
	logic [NW-1:0]       walk_base;
	logic [LETTER_W-1:0] walk_c;

	always_comb begin
		walk_base = cmd.child_q ? node_q : cursor_q;
		walk_c    = cmd.child_q ? ring_rdata : letter_q;
		if (cmd.sweep) begin
			child_addr = sweep_q;
		end else begin
			child_addr = CW'(walk_base) * CW'(ALPHABET_SIZE) + CW'(walk_c);
		end
		child_we    = cmd.sweep || cmd.alloc;
		child_wdata = cmd.sweep ? '0 : nodes_used_q[NW-1:0];
	end

	always_comb begin
		if (cmd.sweep) begin
			term_addr = sweep_q[NW-1:0];
		end else if (cmd.fin) begin
			term_addr = cursor_q;
		end else if (cmd.alloc) begin
			term_addr = nodes_used_q[NW-1:0];
		end else begin
			term_addr = child_rdata;
		end
		term_we = (cmd.sweep && (sweep_q < CW'(NODE_COUNT)))
			|| (cmd.fin && word_done_q && !skip_q);
	end

	assign ring_addr = cmd.ring_wr ? head_q : pos_q;

	ssdm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
		.clk(clk), .addr(child_addr), .we(child_we), .wdata(child_wdata),
		.rdata(child_rdata)
	);

	ssdm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_term (
		.clk(clk), .addr(term_addr), .we(term_we), .wdata(!cmd.sweep),
		.rdata(term_rdata)
	);

	ssdm_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_WORD_LEN)) u_ring (
		.clk(clk), .addr(ring_addr), .we(cmd.ring_wr), .wdata(letter_q),
		.rdata(ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q       <= '0;
			cursor_q     <= '0;
			nodes_used_q <= NUW'(1);
			skip_q       <= 1'b0;
			status_q     <= 1'b0;
			head_q       <= '0;
			pos_q        <= '0;
			fill_q       <= '0;
			step_q       <= '0;
			sweep_q      <= '0;
		end else begin
			if (cmd.ld) begin
				status_q <= 1'b0;
			end
			if (cmd.clr) begin
				nodes_used_q <= NUW'(1);
				head_q       <= '0;
				fill_q       <= '0;
				cursor_q     <= '0;
				skip_q       <= 1'b0;
				sweep_q      <= '0;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_q + CW'(1);
			end
			if (cmd.ring_wr) begin
				head_q <= (head_q == HW'(MAX_WORD_LEN - 1)) ? '0 : head_q + HW'(1);
				pos_q  <= head_q;
				if (fill_q != FW'(MAX_WORD_LEN)) begin
					fill_q <= fill_q + FW'(1);
				end
				step_q <= '0;
				node_q <= '0;
			end
			if (cmd.term_q) begin
				node_q <= child_rdata;
			end
			if (cmd.step) begin
				step_q <= step_q + FW'(1);
				pos_q  <= (pos_q == '0) ? HW'(MAX_WORD_LEN - 1) : pos_q - HW'(1);
			end
			if (cmd.alloc) begin
				cursor_q     <= nodes_used_q[NW-1:0];
				nodes_used_q <= nodes_used_q + NUW'(1);
			end
			if (cmd.adv) begin
				cursor_q <= child_rdata;
			end
			if (cmd.set_skip) begin
				skip_q <= 1'b1;
			end
			if (cmd.set_full) begin
				status_q <= 1'b1;
			end
			if (cmd.fin && word_done_q) begin
				cursor_q <= '0;
				skip_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q        <= item.operation;
			letter_q    <= item.letter;
			word_done_q <= item.word_done;
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.letter_bad = 9'(letter_q) >= 9'(ALPHABET_SIZE);
		sts.skip       = skip_q;
		sts.ring_bad   = 9'(ring_rdata) >= 9'(ALPHABET_SIZE);
		sts.child_zero = child_rdata == '0;
		sts.child_bad  = (child_rdata == '0) || (NUW'(child_rdata) >= NUW'(NODE_COUNT));
		sts.full       = nodes_used_q == NUW'(NODE_COUNT);
		sts.term_hit   = term_rdata;
		sts.last_step  = (step_q + FW'(1)) == fill_q;
		sts.sweep_last = sweep_q == CW'(CD - 1);
		sts.status     = status_q;
	end
endmodule
`default_nettype wire

@@ rtl/ssdm_ctrl.sv @@
`default_nettype none
module ssdm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire ssdm_pkg::sts_t   sts,
	output ssdm_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done,
	output ssdm_pkg::result_t     result
);
	import ssdm_pkg::*;

	localparam logic [3:0] S_SWEEP   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DISP    = 4'd2;
	localparam logic [3:0] S_Q_RING  = 4'd3;
	localparam logic [3:0] S_Q_CHILD = 4'd4;
	localparam logic [3:0] S_Q_TERM  = 4'd5;
	localparam logic [3:0] S_Q_CHK   = 4'd6;
	localparam logic [3:0] S_I_CHILD = 4'd7;
	localparam logic [3:0] S_I_TERM  = 4'd8;
	localparam logic [3:0] S_I_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       pend_q;
	logic       pend_d;
	logic       res;
	logic       res_match;
	logic       res_status;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		pend_d     = pend_q;
		res        = 1'b0;
		res_match  = 1'b0;
		res_status = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
					res     = pend_q;
					pend_d  = 1'b0;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.ld  = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_QUERY: begin
						cmd.ring_wr = 1'b1;
						state_d     = S_Q_RING;
					end
					OP_INSERT: begin
						if (sts.skip) begin
							state_d = S_I_FIN;
						end else if (sts.letter_bad) begin
							cmd.set_skip = 1'b1;
							state_d      = S_I_FIN;
						end else begin
							state_d = S_I_CHILD;
						end
					end
					OP_CLEAR: begin
						cmd.clr = 1'b1;
						pend_d  = 1'b1;
						state_d = S_SWEEP;
					end
					default: begin
						res     = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_Q_RING: begin
				state_d = S_Q_CHILD;
			end
			S_Q_CHILD: begin
				if (sts.ring_bad) begin
					res     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.child_q = 1'b1;
					state_d     = S_Q_TERM;
				end
			end
			S_Q_TERM: begin
				if (sts.child_bad) begin
					res     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.term_q = 1'b1;
					state_d    = S_Q_CHK;
				end
			end
			S_Q_CHK: begin
				if (sts.term_hit) begin
					res       = 1'b1;
					res_match = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.last_step) begin
					res     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_Q_RING;
				end
			end
			S_I_CHILD: begin
				if (sts.child_zero && sts.full) begin
					cmd.set_skip = 1'b1;
					cmd.set_full = 1'b1;
					state_d      = S_I_FIN;
				end else if (sts.child_zero) begin
					cmd.alloc = 1'b1;
					state_d   = S_I_TERM;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_I_TERM;
				end
			end
			S_I_TERM: begin
				cmd.set_skip = sts.term_hit;
				state_d      = S_I_FIN;
			end
			S_I_FIN: begin
				cmd.fin    = 1'b1;
				res        = 1'b1;
				res_status = sts.status;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			pend_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			done    <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (res) begin
			result.matched <= res_match;
			result.status  <= res_status;
		end
	end
endmodule
`default_nettype wire

@@ rtl/stream_suffix_dictionary_matcher.sv @@
// One item at a time: a query raises done when its walk of k trie steps (k at most
// MAX_WORD_LEN) ends; a walk that meets a bad letter or child ends at that step.
// An insert and the unused code also raise done when they finish.
// Reset and a clear run a clearing pass over all NODE_COUNT*ALPHABET_SIZE entries of the child
// table with busy high; a clear raises done when the pass ends.
// Done is a one-cycle strobe, the receiver cannot stall, and a new item may start meanwhile.
`default_nettype none
module stream_suffix_dictionary_matcher #(
	parameter int NODE_COUNT = 4096,
	parameter int MAX_WORD_LEN = 256,
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ssdm_pkg::item_t   item,
	output logic                   busy,
	output logic                   done,
	output ssdm_pkg::result_t      result
);
	import ssdm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ssdm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	ssdm_datapath #(
		.NODE_COUNT(NODE_COUNT), .MAX_WORD_LEN(MAX_WORD_LEN),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .sts(sts)
	);
endmodule
`default_nettype wire

@@ rtl/ssdm_checker.sv @@
`default_nettype none
`include "stream_suffix_dictionary_matcher_macros.svh"
module ssdm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire ssdm_pkg::result_t result
);
	import ssdm_pkg::*;

	`SSDM_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")
	`SSDM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`SSDM_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`SSDM_ASSERT_NOW(a_result_excl, done, !(result.matched && result.status),
		"match and table full reported together")
endmodule

bind stream_suffix_dictionary_matcher ssdm_checker u_ssdm_checker (.*);
`default_nettype wire
